FILE: hw/rtl/sha_pkg.sv
// SHA-256 hasher package: round constants, initial hash values, round functions.
// Used by the front end, the core and the top level; depends on nothing.
`default_nettype none
package sha_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } req_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_PAD, ST_LEN, ST_COMP, ST_OUT
  } core_state_e;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sha_front.sv
// Front end: accepts requests, drops empty ones, queues the rest.
// Depends on sha_pkg.
`default_nettype none
module sha_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               stall_o,
  input  wire sha_pkg::req_t req_i,
  output logic               q_valid_o,
  input  wire logic          q_pop_i,
  output sha_pkg::req_t      q_req_o
);
  import sha_pkg::*;

  req_t                mem_q [QueueDepth];
  logic [QueueAw-1:0]  wp_q, rp_q;
  logic [QueueAw:0]    cnt_q;
  logic                push, pop;

  assign stall_o   = (cnt_q == (QueueAw+1)'(QueueDepth));
  assign push      = valid_i && !stall_o && (req_i.byte_present || req_i.end_of_message);
  assign q_valid_o = (cnt_q != '0);
  assign pop       = q_pop_i && q_valid_o;
  assign q_req_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + QueueAw'(1);
      if (pop)  rp_q <= rp_q + QueueAw'(1);
      cnt_q <= cnt_q + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/sha_core.sv
// Back end: byte loader into the message schedule, padding sequencer,
// one-round-per-cycle compression, digest output. Depends on sha_pkg.
`default_nettype none
module sha_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  output logic               q_pop_o,
  input  wire sha_pkg::req_t q_req_i,
  output logic               valid_o,
  input  wire logic          stall_i,
  output logic [31:0]        digest_word_o,
  output logic [2:0]         word_index_o,
  output logic               last_word_o
);
  import sha_pkg::*;

  core_state_e state_q, state_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [5:0]  rnd_q;
  logic        fin_q, fin_d;
  logic        lastblk_q, lastblk_d;
  logic        pad_pend_q;
  logic [2:0]  oidx_q;

  logic        wr_en;
  logic [7:0]  wr_data;
  logic        start;

  logic [31:0] wt, t1, t2, wn;

  always_comb begin
    wn = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
    wt = w_q[0];
    t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
         + RoundK[rnd_q] + wt;
    t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    bits_d    = bits_q;
    fin_d     = fin_q;
    lastblk_d = lastblk_q;
    q_pop_o   = 1'b0;
    wr_en     = 1'b0;
    wr_data   = q_req_i.msg_byte;
    start     = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          fin_d   = q_req_i.end_of_message;
          if (q_req_i.byte_present) begin
            wr_en  = 1'b1;
            bits_d = bits_q + 64'd8;
            fill_d = fill_q + 6'd1;
            if (fill_q == 6'd63) begin
              lastblk_d = 1'b0;
              start     = 1'b1;
              state_d   = ST_COMP;
            end else if (q_req_i.end_of_message) begin
              state_d = ST_PAD;
            end
          end else begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_data = fin_q ? PadByte : 8'h00;
        fin_d   = 1'b0;
        fill_d  = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          lastblk_d = 1'b0;
          start     = 1'b1;
          state_d   = ST_COMP;
        end else if (fill_q == 6'd55) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        wr_en   = 1'b1;
        wr_data = bits_q[{~fill_q[2:0], 3'b000} +: 8];
        fill_d  = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          lastblk_d = 1'b1;
          start     = 1'b1;
          state_d   = ST_COMP;
        end
      end
      ST_COMP: begin
        if (rnd_q == 6'd63) begin
          if (lastblk_q) state_d = ST_OUT;
          else if (pad_pend_q) state_d = ST_PAD;
          else state_d = ST_LOAD;
        end
      end
      ST_OUT: begin
        if (!stall_i && oidx_q == 3'd7) begin
          state_d = ST_LOAD;
          bits_d  = '0;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_COMP) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
    end else begin
      if (wr_en) begin
        for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
        w_q[15] <= {w_q[15][23:0], wr_data};
      end
      if (start)
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      fill_q     <= '0;
      bits_q     <= '0;
      fin_q      <= 1'b0;
      lastblk_q  <= 1'b0;
      pad_pend_q <= 1'b0;
      rnd_q      <= '0;
      oidx_q     <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      bits_q    <= bits_d;
      fin_q     <= fin_d;
      lastblk_q <= lastblk_d;
      if (start) pad_pend_q <= (state_q == ST_PAD) || (state_q == ST_LOAD && fin_d);
      if (state_q == ST_COMP) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          h_q[0] <= h_q[0] + t1 + t2;
          h_q[1] <= h_q[1] + v_q[0];
          h_q[2] <= h_q[2] + v_q[1];
          h_q[3] <= h_q[3] + v_q[2];
          h_q[4] <= h_q[4] + v_q[3] + t1;
          h_q[5] <= h_q[5] + v_q[4];
          h_q[6] <= h_q[6] + v_q[5];
          h_q[7] <= h_q[7] + v_q[6];
        end
      end
      if (state_q == ST_OUT && !stall_i) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7)
          for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
      end
    end
  end

  assign valid_o       = (state_q == ST_OUT);
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);
endmodule
`default_nettype wire

FILE: hw/rtl/sha256_message_hasher.sv
// SHA-256 message hasher top level: front queue feeding the compression core.
// Depends on sha_pkg, sha_front, sha_core.
//
// Input channel: valid_i/stall_o with msg_byte_i, byte_present_i,
// end_of_message_i. Items with neither flag set are dropped at the front.
// Output channel: valid_o/stall_i with digest_word_o, word_index_o,
// last_word_o; eight words per end item, word 0 first.
// Each byte is shifted into the message schedule; every 64th byte starts a
// compression (one round per cycle on the single round unit). An end item
// pads one byte per cycle up to the block end, compresses (a second block
// when 56+ bytes were held), shows eight words, one per unstalled cycle.
// A four-entry queue takes requests while the core compresses, until full.
// Reset loads the initial hash values, empties the queue and clears the
// byte and bit counts.
// While stall_i is high the current word holds and the core waits.
`default_nettype none
module sha256_message_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [7:0]  msg_byte_i,
  input  wire logic        byte_present_i,
  input  wire logic        end_of_message_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);
  import sha_pkg::*;

  req_t req, q_req;
  logic q_valid, q_pop;

  assign req = '{msg_byte: msg_byte_i, byte_present: byte_present_i,
                 end_of_message: end_of_message_i};

  sha_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .req_i(req),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req)
  );

  sha_core u_core (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_req_i(q_req),
    .valid_o, .stall_i, .digest_word_o, .word_index_o, .last_word_o
  );
endmodule
`default_nettype wire

FILE: hw/rtl/sha_checker.sv
// Port-level checks for the SHA-256 hasher, bound to the top level.
// Depends on sha256_message_hasher ports only.
`default_nettype none
module sha_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_o,
  input wire logic        stall_i,
  input wire logic [31:0] digest_word_o,
  input wire logic [2:0]  word_index_o,
  input wire logic        last_word_o
);
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last_word mismatch");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(digest_word_o) && $stable(word_index_o))
    else $error("stalled word changed");
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i && !last_word_o |=> valid_o && word_index_o == $past(word_index_o) + 3'd1)
    else $error("digest words not consecutive");
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> word_index_o == 3'd0)
    else $error("digest does not start at word 0");
endmodule

bind sha256_message_hasher sha_checker u_sha_checker (
  .clk_i, .rst_ni, .valid_o, .stall_i, .digest_word_o, .word_index_o, .last_word_o
);
`default_nettype wire
